>>> rtl/bfdh_pkg.sv
// ----------------------------------------------------------------------------
// bfdh_pkg: shared definitions for the double-hash bloom filter
// Field widths, register indexes, command codes and the word types that pass
// between the control logic and the bit store.
// ----------------------------------------------------------------------------
package bfdh_pkg;

   // field widths
   localparam int KEY_W      = 64;
   localparam int HALF_W     = 32;
   localparam int BIT_SEL_W  = 5;     // bit inside a 32-bit store word
   localparam int NH_W       = 5;     // num_hashes register
   localparam int NW_W       = 11;    // num_words register
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 11;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_HASHES = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_WORDS  = 2'd1;

   // register reset values
   localparam logic [NH_W-1:0] NH_RESET = 5'd3;
   localparam logic [NW_W-1:0] NW_RESET = 11'd1024;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // sizing defaults and limits
   localparam int DEFAULT_MAX_WORDS = 1024;
   localparam int MAX_HASHES        = 16;
   localparam int MIN_HASHES        = 2;

   // remainder unit: word index of a 32-bit hash value (upper 27 bits),
   // padded to an even width, two quotient bits per cycle
   localparam int QUO_W     = 28;
   localparam int REM_STEPS = QUO_W / 2;
   localparam int REM_CNT_W = 4;

   // 2^27, the weight of the wrap out of a 27-bit word index
   localparam logic [QUO_W-1:0] WRAP_DIVIDEND = 28'h800_0000;

   // one bit-store access request
   typedef struct packed {
      logic                 go;
      logic                 wr;
      logic [NW_W-1:0]      word;
      logic [BIT_SEL_W-1:0] bit_sel;
   } store_req_type;

   // bit-store status
   typedef struct packed {
      logic clearing;
      logic hit_valid;
      logic hit;
   } store_rsp_type;

endpackage

>>> rtl/bfdh_if.sv
// ----------------------------------------------------------------------------
// bfdh_req_if / bfdh_rsp_if: valid/ready channels of the bloom filter
// A word moves at a rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface bfdh_req_if import bfdh_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [KEY_W-1:0] key_hash;

   modport source (output valid, cmd, key_hash, input ready);
   modport sink   (input valid, cmd, key_hash, output ready);
endinterface

interface bfdh_rsp_if import bfdh_pkg::*; ();
   logic valid;
   logic ready;
   logic present;

   modport source (output valid, present, input ready);
   modport sink   (input valid, present, output ready);
endinterface

>>> rtl/bfdh_rem_unit.sv
// ----------------------------------------------------------------------------
// bfdh_rem_unit: iterative remainder
// Restoring division of a 28-bit dividend by an 11-bit divisor, two bits
// per cycle; done pulses one cycle with the remainder valid.
// ----------------------------------------------------------------------------
module bfdh_rem_unit import bfdh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [QUO_W-1:0] dividend,
   input  logic [NW_W-1:0]  divisor,
   output logic             done,
   output logic [NW_W-1:0]  rem
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [QUO_W-1:0]     sh_ff, sh_in;
   logic [NW_W-1:0]      rem_ff, rem_in;

   logic [NW_W:0] div_ext;
   logic [NW_W:0] t1, t1r, t2, t2r;

   // two restoring steps
   always_comb begin
      div_ext = {1'b0, divisor};
      t1      = {rem_ff, sh_ff[QUO_W-1]};
      t1r     = (t1 >= div_ext) ? t1 - div_ext : t1;
      t2      = {t1r[NW_W-1:0], sh_ff[QUO_W-2]};
      t2r     = (t2 >= div_ext) ? t2 - div_ext : t2;
   end

   // sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         sh_in  = {sh_ff[QUO_W-3:0], 2'b00};
         rem_in = t2r[NW_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == REM_CNT_W'(REM_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

>>> rtl/bfdh_store.sv
// ----------------------------------------------------------------------------
// bfdh_store: bit store of the bloom filter
// One synchronous memory of 32-bit words. A request reads a word; the next
// cycle reports the selected bit and, for an insert, writes the word back
// with that bit set. After reset a pass clears every word.
// ----------------------------------------------------------------------------
module bfdh_store import bfdh_pkg::*; #(
   parameter int MAX_WORDS = DEFAULT_MAX_WORDS
) (
   input  logic          clock,
   input  logic          reset,
   input  store_req_type req,
   output store_rsp_type st
);

   localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   logic [HALF_W-1:0]    mem_ff [MAX_WORDS];
   logic [HALF_W-1:0]    rd_data_ff;
   logic                 pend_ff, pend_in;
   logic                 wr_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [BIT_SEL_W-1:0] bit_ff;
   logic                 clearing_ff, clearing_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [HALF_W-1:0]    mem_wdata;
   logic [ADDR_W-1:0]    rd_addr;
   logic [HALF_W-1:0]    mask;

   // clearing pass, one word a cycle
   always_comb begin
      clearing_in = clearing_ff;
      clr_in      = clr_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == ADDR_W'(MAX_WORDS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // write port: clearing or read-modify-write
   always_comb begin
      rd_addr   = ADDR_W'(req.word);
      mask      = HALF_W'(1) << bit_ff;
      pend_in   = req.go;
      mem_we    = clearing_ff | (pend_ff & wr_ff);
      mem_waddr = clearing_ff ? clr_ff : addr_ff;
      mem_wdata = clearing_ff ? '0 : (rd_data_ff | mask);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 1'b0;
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else begin
         pend_ff     <= pend_in;
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
      end
      if (req.go) begin
         wr_ff   <= req.wr;
         addr_ff <= rd_addr;
         bit_ff  <= req.bit_sel;
      end
   end

   // memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign st.clearing  = clearing_ff;
   assign st.hit_valid = pend_ff;
   assign st.hit       = |(rd_data_ff & mask);

endmodule

>>> rtl/bloom_filter_double_hash.sv
// Sequence: an accepted word goes through the remainder step and its hand-off, then one
// read-modify-write on the memory port per position (k positions, k being the effective hash
// count, 2..16), then loads the output register once that register is free.
// Throughput: one item at a time; the next word is taken the cycle after the result is loaded.
// Reset: synchronous; a pass then clears every store word, no word taken meanwhile.
// ----------------------------------------------------------------------------
// bloom_filter_double_hash: bloom filter with double hashing
// Insert sets k bit positions derived from a 64-bit key hash; query reports
// whether all k positions are set. Positions advance incrementally modulo m.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash import bfdh_pkg::*; #(
   parameter int MAX_WORDS = DEFAULT_MAX_WORDS
) (
   input  logic                  clock,
   input  logic                  reset,
   bfdh_req_if.sink              req_bus,
   bfdh_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_POS,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [NH_W-1:0]   nh_ff;
   logic [NW_W-1:0]   nw_ff;
   logic              cmd_ff, cmd_in;
   logic [HALF_W-1:0] y_ff, y_in;
   logic [HALF_W-1:0] h2_ff, h2_in;
   logic [NW_W-1:0]   ry_ff, ry_in;
   logic [NW_W-1:0]   rh_ff, rh_in;
   logic [NW_W-1:0]   c_ff, c_in;
   logic [NH_W-1:0]   idx_ff, idx_in;
   logic              all_set_ff, all_set_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_present_ff, rsp_present_in;

   logic [NH_W-1:0]   k_eff;
   logic [NW_W-1:0]   w_eff;
   logic              accept;
   logic              div_done;
   logic [NW_W-1:0]   r1, r2, rc;
   logic              h2_done;
   logic              wrap_done;

   logic [HALF_W:0]   y_sum;
   logic [BIT_SEL_W:0] lo_sum;
   logic [NW_W:0]     w12, c12, s0, s1, s2;
   logic [NW_W-1:0]   ry_next;

   store_req_type     store_req;
   store_rsp_type     store_st;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nh_ff <= NH_RESET;
         nw_ff <= NW_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_NUM_HASHES: nh_ff <= csr_wdata[NH_W-1:0];
            CSR_NUM_WORDS:  nw_ff <= csr_wdata[NW_W-1:0];
            default: ;
         endcase
      end
   end

   // effective hash count and word count
   always_comb begin
      if (nh_ff < NH_W'(MIN_HASHES)) begin
         k_eff = NH_W'(MIN_HASHES);
      end else if (32'(nh_ff) > 32'(MAX_HASHES)) begin
         k_eff = NH_W'(MAX_HASHES);
      end else begin
         k_eff = nh_ff;
      end
      if (nw_ff == '0) begin
         w_eff = NW_W'(1);
      end else if (32'(nw_ff) > 32'(MAX_WORDS)) begin
         w_eff = NW_W'(MAX_WORDS);
      end else begin
         w_eff = nw_ff;
      end
   end

   assign req_bus.ready = (state_ff == S_IDLE) && !store_st.clearing;
   assign accept        = req_bus.valid && req_bus.ready;

   // word index remainders of h1, h2 and the 2^27 wrap, in lock-step
   bfdh_rem_unit u_rem_h1 (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend ({1'b0, req_bus.key_hash[KEY_W-1:HALF_W+BIT_SEL_W]}),
      .divisor  (w_eff),
      .done     (div_done),
      .rem      (r1)
   );

   bfdh_rem_unit u_rem_h2 (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend ({1'b0, req_bus.key_hash[HALF_W-1:BIT_SEL_W]}),
      .divisor  (w_eff),
      .done     (h2_done),
      .rem      (r2)
   );

   bfdh_rem_unit u_rem_wrap (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (WRAP_DIVIDEND),
      .divisor  (w_eff),
      .done     (wrap_done),
      .rem      (rc)
   );

   // next running position: y + h2, remainder kept modulo the word count
   always_comb begin
      y_sum   = {1'b0, y_ff} + {1'b0, h2_ff};
      lo_sum  = {1'b0, y_ff[BIT_SEL_W-1:0]} + {1'b0, h2_ff[BIT_SEL_W-1:0]};
      w12     = {1'b0, w_eff};
      c12     = {1'b0, c_ff};
      s0      = {1'b0, ry_ff} + {1'b0, rh_ff} + {{NW_W{1'b0}}, lo_sum[BIT_SEL_W]};
      s1      = (s0 >= w12) ? s0 - w12 : s0;
      s2      = (s1 >= c12) ? s1 - c12 : s1 + w12 - c12;
      ry_next = y_sum[HALF_W] ? s2[NW_W-1:0] : s1[NW_W-1:0];
   end

   // store request for the current position; the second one is h2 itself
   always_comb begin
      store_req.go      = (state_ff == S_POS) && !store_st.hit_valid;
      store_req.wr      = (cmd_ff == CMD_INSERT);
      store_req.word    = (idx_ff == NH_W'(1)) ? rh_ff : ry_ff;
      store_req.bit_sel = (idx_ff == NH_W'(1)) ? h2_ff[BIT_SEL_W-1:0]
                                               : y_ff[BIT_SEL_W-1:0];
   end

   bfdh_store #(
      .MAX_WORDS (MAX_WORDS)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .req   (store_req),
      .st    (store_st)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      y_in           = y_ff;
      h2_in          = h2_ff;
      ry_in          = ry_ff;
      rh_in          = rh_ff;
      c_in           = c_ff;
      idx_in         = idx_ff;
      all_set_in     = all_set_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_present_in = rsp_present_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_bus.cmd;
               y_in     = req_bus.key_hash[KEY_W-1:HALF_W];
               h2_in    = req_bus.key_hash[HALF_W-1:0];
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done && h2_done && wrap_done) begin
               ry_in      = r1;
               rh_in      = r2;
               c_in       = rc;
               idx_in     = '0;
               all_set_in = 1'b1;
               state_in   = S_POS;
            end
         end
         S_POS: begin
            if (store_st.hit_valid) begin
               all_set_in = all_set_ff & store_st.hit;
               y_in       = y_sum[HALF_W-1:0];
               ry_in      = ry_next;
               idx_in     = idx_ff + 1'b1;
               if (idx_ff == k_eff - 1'b1) begin
                  state_in = S_RESP;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_present_in = (cmd_ff == CMD_QUERY) && all_set_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      y_ff           <= y_in;
      h2_ff          <= h2_in;
      ry_ff          <= ry_in;
      rh_ff          <= rh_in;
      c_ff           <= c_in;
      idx_ff         <= idx_in;
      all_set_ff     <= all_set_in;
      rsp_present_ff <= rsp_present_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.present = rsp_present_ff;

   // no word is taken while the store is being cleared
   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset) accept |-> !store_st.clearing
   ) else $error("word accepted during clearing pass");

   // an accepted word starts the remainder step
   a_accept_starts_div: assert property (
      @(posedge clock) disable iff (reset) accept |=> (state_ff == S_DIV)
   ) else $error("accepted word did not start remainder step");

   // position index stays inside the hash count
   a_idx_in_range: assert property (
      @(posedge clock) disable iff (reset) (state_ff == S_POS) |-> (idx_ff < k_eff)
   ) else $error("position index beyond hash count");

   // a new store access never overlaps a pending read-modify-write
   a_no_overlap: assert property (
      @(posedge clock) disable iff (reset) store_req.go |-> !store_st.hit_valid
   ) else $error("store access issued while one is pending");

endmodule

>>> verif/bloom_filter_double_hash_test.sv
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_test: self-checking bench for the bloom filter
// Streams insert and query words through the request channel, keeps a shadow
// bit store and register copy to predict each present flag, and compares
// every response word in order. Runs directed corner keys first, then random
// segments with a fresh register setting each, under varying backpressure.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_test;
   import bfdh_pkg::*;

   localparam int WORD_BITS   = 32;
   localparam int STORE_WORDS = DEFAULT_MAX_WORDS;
   localparam int STORE_AW    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int FLIP_W      = $clog2(KEY_W);
   localparam int SEG_WORDS   = 30;
   localparam int SEGMENTS    = 5;
   localparam int SETTLE      = 4;
   localparam int END_WAIT    = 60;
   localparam int STALL_LIMIT = 4000;
   localparam int KNOWN_DEPTH = 64;

   // register indexes that map to nothing
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_B = 2'd3;

   typedef struct {
      logic             cmd;
      logic [KEY_W-1:0] key;
   } lookup_word_type;

   typedef struct {
      logic             cmd;
      logic [KEY_W-1:0] key;
      logic             present;
   } lookup_answer_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bfdh_req_if req_bus ();
   bfdh_rsp_if rsp_bus ();

   // shadow of the filter state
   logic [WORD_BITS-1:0] filter_bits [STORE_WORDS];
   logic [NH_W-1:0]      nh_reg = NH_RESET;
   logic [NW_W-1:0]      nw_reg = NW_RESET;

   lookup_word_type   words_to_send [$];
   lookup_answer_type answers_due [$];
   logic [KEY_W-1:0]  known_keys [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;

   bloom_filter_double_hash uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // present flag for one word; inserts update the shadow store
   function automatic logic predict_present(input logic cmd, input logic [KEY_W-1:0] key);
      logic [HALF_W-1:0] h1, h2, pos_hash, step;
      int unsigned       k, m, p, w;
      logic              all_set;
      h1 = key[KEY_W-1:HALF_W];
      h2 = key[HALF_W-1:0];
      k = 32'(nh_reg);
      if (k < MIN_HASHES) k = MIN_HASHES;
      if (k > MAX_HASHES) k = MAX_HASHES;
      m = 32'(nw_reg);
      if (m == 0) m = 1;
      if (m > STORE_WORDS) m = STORE_WORDS;
      m = m * WORD_BITS;
      all_set = 1'b1;
      for (step = 0; step < k; step++) begin
         // first two positions straight from the halves, then h1 + i*h2 with wrap
         pos_hash = (step == 0) ? h1 : (step == 1) ? h2 : h1 + h2 * step;
         p = pos_hash % m;
         w = (p / WORD_BITS) % STORE_WORDS;
         if (cmd == CMD_INSERT) begin
            filter_bits[w[STORE_AW-1:0]][p[BIT_SEL_W-1:0]] = 1'b1;
         end else if (!filter_bits[w[STORE_AW-1:0]][p[BIT_SEL_W-1:0]]) begin
            all_set = 1'b0;
         end
      end
      return (cmd == CMD_QUERY) && all_set;
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      logic [KEY_W-1:0] key;
      key = {$urandom, $urandom};
      case ($urandom_range(9))
         0: key[KEY_W-1:HALF_W] = '1;
         1: key[HALF_W-1:0] = '0;
         2: key[HALF_W-1:0] = key[KEY_W-1:HALF_W];
         default: ;
      endcase
      return key;
   endfunction

   task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key);
      lookup_word_type item;
      item.cmd = cmd;
      item.key = key;
      words_to_send.push_back(item);
      if (cmd == CMD_INSERT) begin
         known_keys.push_back(key);
         if (known_keys.size() > KNOWN_DEPTH) void'(known_keys.pop_front());
      end
   endtask

   // wait until every queued word went out and every answer came back
   task automatic drain();
      while (words_to_send.size() != 0 || req_bus.valid || answers_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      // mirror the write; unused indexes change nothing
      if (addr == CSR_NUM_HASHES) nh_reg = data[NH_W-1:0];
      else if (addr == CSR_NUM_WORDS) nw_reg = data[NW_W-1:0];
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] nh_data,
                             input logic [CSR_DATA_W-1:0] nw_data);
      drain();
      write_reg(CSR_NUM_HASHES, nh_data);
      write_reg(CSR_NUM_WORDS, nw_data);
   endtask

   // one random register setting followed by a burst of mixed words
   task automatic run_segment();
      logic [CSR_DATA_W-1:0] nh_data, nw_data;
      logic [KEY_W-1:0]      key;
      logic [FLIP_W-1:0]     flip;
      int                    i, r;
      case ($urandom_range(7))
         0: nh_data = 0;
         1: nh_data = 1;
         2: nh_data = CSR_DATA_W'(MIN_HASHES);
         3: nh_data = CSR_DATA_W'(MAX_HASHES);
         4: nh_data = 31;
         5: nh_data = CSR_DATA_W'($urandom);
         default: nh_data = CSR_DATA_W'($urandom_range(3, 8));
      endcase
      case ($urandom_range(8))
         0: nw_data = 0;
         1: nw_data = 1;
         2: nw_data = CSR_DATA_W'(STORE_WORDS);
         3: nw_data = 2047;
         4: nw_data = CSR_DATA_W'($urandom);
         5: nw_data = CSR_DATA_W'($urandom_range(STORE_WORDS + 1, 2047));
         6: nw_data = CSR_DATA_W'($urandom_range(65, STORE_WORDS));
         default: nw_data = CSR_DATA_W'($urandom_range(1, 64));
      endcase
      set_config(nh_data, nw_data);
      if ($urandom_range(2) == 0)
         write_reg($urandom_range(1) ? CSR_UNUSED_A : CSR_UNUSED_B, CSR_DATA_W'($urandom));
      for (i = 0; i < SEG_WORDS; i++) begin
         r = $urandom_range(99);
         if (r < 40 || known_keys.size() == 0) begin
            send_word(r < 40 ? CMD_INSERT : CMD_QUERY, random_key());
         end else if (r < 70) begin
            send_word(CMD_QUERY, known_keys[$urandom_range(known_keys.size() - 1)]);
         end else if (r < 85) begin
            // near miss of a stored key
            key = known_keys[$urandom_range(known_keys.size() - 1)];
            flip = FLIP_W'($urandom_range(KEY_W - 1));
            key[flip] ^= 1'b1;
            send_word(CMD_QUERY, key);
         end else begin
            send_word(CMD_QUERY, random_key());
         end
      end
   endtask

   // request driver: log the answer of each taken word, then offer the next
   always @(posedge clock) begin
      lookup_word_type   item;
      lookup_answer_type answer;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.cmd <= CMD_INSERT;
         req_bus.key_hash <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            answer.cmd = req_bus.cmd;
            answer.key = req_bus.key_hash;
            answer.present = predict_present(req_bus.cmd, req_bus.key_hash);
            answers_due.push_back(answer);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = words_to_send.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.cmd <= item.cmd;
               req_bus.key_hash <= item.key;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random backpressure
   always @(posedge clock) begin
      lookup_answer_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected response word: expected none, got present=%0b",
                        $time, rsp_bus.present);
               mismatches++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_bus.present !== due.present) begin
                  $display("%0t: %s key %h: expected present=%0b, got present=%0b",
                           $time, due.cmd == CMD_QUERY ? "query" : "insert", due.key,
                           due.present, rsp_bus.present);
                  mismatches++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any progress
   initial begin : watchdog
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_we)
            stall = 0;
         else
            stall++;
      end
      $display("bloom_filter_double_hash verification failed");
      $finish;
   end

   initial begin
      int phase, seg;
      foreach (filter_bits[i]) filter_bits[i] = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset values written again during the clearing pass
      write_reg(CSR_NUM_HASHES, CSR_DATA_W'(NH_RESET));
      write_reg(CSR_NUM_WORDS, NW_RESET);

      send_idle_pct = 33;
      recv_idle_pct = 51;

      // directed: empty store, extreme keys and 32-bit wrap of h1 + i*h2
      send_word(CMD_QUERY, 64'h0);
      send_word(CMD_INSERT, 64'h0);
      send_word(CMD_QUERY, 64'h0);
      send_word(CMD_QUERY, '1);
      send_word(CMD_INSERT, '1);
      send_word(CMD_QUERY, '1);
      send_word(CMD_INSERT, 64'hffff_ffff_0000_0000);
      send_word(CMD_QUERY, 64'h0000_0000_ffff_ffff);

      // saturated hash count and size, then writes to unused indexes
      set_config(31, 2047);
      write_reg(CSR_UNUSED_A, '1);
      write_reg(CSR_UNUSED_B, 0);
      send_word(CMD_INSERT, 64'h8000_0000_7fff_ffff);
      send_word(CMD_QUERY, 64'h8000_0000_7fff_ffff);
      send_word(CMD_QUERY, 64'h7fff_ffff_8000_0000);

      // zero count and zero size act as the minimum
      set_config(0, 0);
      send_word(CMD_QUERY, 64'h0000_001f_0000_0000);
      send_word(CMD_INSERT, 64'h0000_001f_0000_0001);
      send_word(CMD_QUERY, 64'h0000_003f_0000_0021);

      // count of one, upper data bits of the hash count write dropped
      set_config(11'h7e1, 1);
      send_word(CMD_QUERY, 64'h1234_5678_9abc_def0);

      // grow again: old bits stay in place
      set_config(CSR_DATA_W'(MIN_HASHES), CSR_DATA_W'(STORE_WORDS));
      send_word(CMD_QUERY, 64'h0);
      send_word(CMD_INSERT, 64'hdead_beef_0bad_f00d);

      set_config(CSR_DATA_W'(MAX_HASHES), 1);
      send_word(CMD_INSERT, '1);
      send_word(CMD_QUERY, '1);

      set_config(CSR_DATA_W'(NH_RESET), 2);
      send_word(CMD_QUERY, 64'h0);
      send_word(CMD_QUERY, 64'h0000_0020_0000_0040);

      // random segments under three backpressure profiles
      for (phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 51;
            recv_idle_pct = 33;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (seg = 0; seg < SEGMENTS; seg++)
            run_segment();
      end

      drain();
      repeat (END_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("bloom_filter_double_hash verification clean");
      else
         $display("bloom_filter_double_hash verification failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/bfdh_pkg.sv
rtl/bfdh_if.sv
rtl/bfdh_rem_unit.sv
rtl/bfdh_store.sv
rtl/bloom_filter_double_hash.sv
verif/bloom_filter_double_hash_test.sv
